@@ hdl/obvc_pkg.sv @@
// package: types, sine table and helpers for the oriented box vertex contact block
package obvc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW  = 31;
  localparam int unsigned AngleW = 16;
  localparam int unsigned TrigW  = 16;
  localparam int unsigned FifoDepth = 16;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic [15:0]        a_angle;
    logic [30:0]        a_width;
    logic [30:0]        a_height;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic [15:0]        b_angle;
    logic [30:0]        b_width;
    logic [30:0]        b_height;
  } box_pair_t;

  typedef struct packed {
    logic               contact_found;
    logic [30:0]        penetration;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] edge_point_b_x;
    logic signed [31:0] edge_point_b_y;
  } contact_t;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  // q1.14 sine at k*pi/128, k = 0..64
  function automatic logic [14:0] sine_rom(input logic [6:0] k);
    logic [14:0] r;
    case (k)
      7'd0: r = 15'd0;      7'd1: r = 15'd402;    7'd2: r = 15'd804;
      7'd3: r = 15'd1205;   7'd4: r = 15'd1606;   7'd5: r = 15'd2006;
      7'd6: r = 15'd2404;   7'd7: r = 15'd2801;   7'd8: r = 15'd3196;
      7'd9: r = 15'd3590;   7'd10: r = 15'd3981;  7'd11: r = 15'd4370;
      7'd12: r = 15'd4756;  7'd13: r = 15'd5139;  7'd14: r = 15'd5520;
      7'd15: r = 15'd5897;  7'd16: r = 15'd6270;  7'd17: r = 15'd6639;
      7'd18: r = 15'd7005;  7'd19: r = 15'd7366;  7'd20: r = 15'd7723;
      7'd21: r = 15'd8076;  7'd22: r = 15'd8423;  7'd23: r = 15'd8765;
      7'd24: r = 15'd9102;  7'd25: r = 15'd9434;  7'd26: r = 15'd9760;
      7'd27: r = 15'd10080; 7'd28: r = 15'd10394; 7'd29: r = 15'd10702;
      7'd30: r = 15'd11003; 7'd31: r = 15'd11297; 7'd32: r = 15'd11585;
      7'd33: r = 15'd11866; 7'd34: r = 15'd12140; 7'd35: r = 15'd12406;
      7'd36: r = 15'd12665; 7'd37: r = 15'd12916; 7'd38: r = 15'd13160;
      7'd39: r = 15'd13395; 7'd40: r = 15'd13623; 7'd41: r = 15'd13842;
      7'd42: r = 15'd14053; 7'd43: r = 15'd14256; 7'd44: r = 15'd14449;
      7'd45: r = 15'd14635; 7'd46: r = 15'd14811; 7'd47: r = 15'd14978;
      7'd48: r = 15'd15137; 7'd49: r = 15'd15286; 7'd50: r = 15'd15426;
      7'd51: r = 15'd15557; 7'd52: r = 15'd15679; 7'd53: r = 15'd15791;
      7'd54: r = 15'd15893; 7'd55: r = 15'd15986; 7'd56: r = 15'd16069;
      7'd57: r = 15'd16143; 7'd58: r = 15'd16207; 7'd59: r = 15'd16261;
      7'd60: r = 15'd16305; 7'd61: r = 15'd16340; 7'd62: r = 15'd16364;
      7'd63: r = 15'd16379; default: r = 15'd16384;
    endcase
    return r;
  endfunction

  // interpolated table sine, q1.14, from a 16-bit binary angle
  function automatic logic signed [15:0] sin_q14(input logic [15:0] angle);
    logic [1:0]         quad;
    logic [14:0]        p;
    logic [14:0]        lo;
    logic [14:0]        hi;
    logic signed [16:0] diff;
    logic signed [25:0] prod;
    logic signed [25:0] rnd;
    logic signed [15:0] v;
    quad = angle[15:14];
    p = {1'b0, angle[13:0]};
    if (quad[0]) p = 15'd16384 - p;
    if (p[14:8] >= 7'd64) begin
      v = 16'sd16384;
    end else begin
      lo = sine_rom(p[14:8]);
      hi = sine_rom(p[14:8] + 7'd1);
      diff = $signed({2'b00, hi}) - $signed({2'b00, lo});
      prod = diff * $signed({1'b0, p[7:0]});
      rnd = (prod + 26'sd128) >>> 8;
      v = $signed({1'b0, lo}) + rnd[15:0];
    end
    return quad[1] ? -v : v;
  endfunction

  // floor(x/16384 + 1/2)
  function automatic logic signed [35:0] rshift14(input logic signed [49:0] x);
    logic signed [49:0] t;
    t = (x + 50'sd8192) >>> 14;
    return t[35:0];
  endfunction

endpackage

@@ hdl/obvc_stream_if.sv @@
// valid/ready channel carrying one payload beat
interface obvc_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/oriented_box_vertex_contact.sv @@
// top level: deepest corner contact of box a into box b, deep pipeline
// Use: box pairs enter on the in channel (obvc_stream_if, box_pair_t) and
// one contact_t beat leaves on the out channel for every pair, in order.
// A beat is taken when valid and ready are high at a rising clk edge.
// An accepted beat passes stages 1 to 6, then the output queue, to out.valid.
// Throughput is one pair per cycle while in.ready is high; six register
// stages hold the work, with multipliers in stage 2 (16x32) and 4 (16x38).
// Stage 1 reads sines and cosines, 2 forms the rotated half sizes,
// 3 places corners relative to b's centre, 4 maps them into b's frame,
// 5 picks edges, 6 picks the deepest corner.
// The pipeline advances only as a whole; results land in a 16-entry output
// queue, and in.ready drops once queued plus in-flight beats reach 15, one
// short of its depth, so a stalled receiver loses and repeats nothing.
// Reset (rst, synchronous, active high) clears all valid bits and the queue;
// no item is in flight after reset. There are no configuration registers.
module oriented_box_vertex_contact (
  input logic clk,
  input logic rst,
  obvc_stream_if.sink   in,
  obvc_stream_if.source out
);

  localparam int unsigned Stages = 6;
  localparam int unsigned PtrW = $clog2(obvc_pkg::FifoDepth);

  logic [Stages-1:0] vld;
  logic              take;
  logic [PtrW:0]     count;
  logic [PtrW:0]     inflight;

  assign inflight = PtrW'(0) + (PtrW+1)'($countones(vld));
  assign in.ready = (count + inflight) < (PtrW+1)'(obvc_pkg::FifoDepth - 1);
  assign take = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Stages-2:0], take};
  end

  // stage 1
  logic signed [15:0] ca, sa, cb, sb;
  logic signed [31:0] hwa, hha, hwb, hhb;
  logic signed [31:0] ax1, ay1, bx1, by1;
  always_ff @(posedge clk) begin
    ca  <= obvc_pkg::sin_q14(in.data.a_angle + 16'd16384);
    sa  <= obvc_pkg::sin_q14(in.data.a_angle);
    cb  <= obvc_pkg::sin_q14(in.data.b_angle + 16'd16384);
    sb  <= obvc_pkg::sin_q14(in.data.b_angle);
    hwa <= {2'b00, in.data.a_width[30:1]};
    hha <= {2'b00, in.data.a_height[30:1]};
    hwb <= {2'b00, in.data.b_width[30:1]};
    hhb <= {2'b00, in.data.b_height[30:1]};
    ax1 <= in.data.a_pos_x;
    ay1 <= in.data.a_pos_y;
    bx1 <= in.data.b_pos_x;
    by1 <= in.data.b_pos_y;
  end

  // stage 2: rotated half-size products
  logic signed [47:0] cwx, swx, chy, shy;
  logic signed [15:0] cb2, sb2;
  logic signed [31:0] hwa2, hha2, hwb2, hhb2, ax2, ay2, bx2, by2;
  always_ff @(posedge clk) begin
    cwx <= ca * hwa;
    swx <= sa * hwa;
    chy <= ca * hha;
    shy <= sa * hha;
    cb2 <= cb; sb2 <= sb;
    hwa2 <= hwa; hha2 <= hha; hwb2 <= hwb; hhb2 <= hhb;
    ax2 <= ax1; ay2 <= ay1; bx2 <= bx1; by2 <= by1;
  end

  // stage 3: world offsets from b centre
  logic signed [37:0] dx3 [4];
  logic signed [37:0] dy3 [4];
  logic signed [15:0] cb3, sb3;
  logic signed [31:0] hwa3, hha3, hwb3, hhb3;
  always_ff @(posedge clk) begin
    for (int v = 0; v < 4; v++) begin
      logic signed [49:0] px;
      logic signed [49:0] py;
      logic signed [49:0] cx;
      logic signed [49:0] cy;
      cx = (v == 0 || v == 3) ? -50'(cwx) : 50'(cwx);
      cy = (v < 2) ? -50'(shy) : 50'(shy);
      px = cx - cy;
      cx = (v == 0 || v == 3) ? -50'(swx) : 50'(swx);
      cy = (v < 2) ? -50'(chy) : 50'(chy);
      py = cx + cy;
      dx3[v] <= 38'(ax2) + 38'(obvc_pkg::rshift14(px)) - 38'(bx2);
      dy3[v] <= 38'(ay2) + 38'(obvc_pkg::rshift14(py)) - 38'(by2);
    end
    cb3 <= cb2; sb3 <= sb2;
    hwa3 <= hwa2; hha3 <= hha2; hwb3 <= hwb2; hhb3 <= hhb2;
  end

  // stage 4: b frame
  logic signed [35:0] lx4 [4];
  logic signed [35:0] ly4 [4];
  logic signed [15:0] cb4, sb4;
  logic signed [31:0] hwa4, hha4, hwb4, hhb4;
  always_ff @(posedge clk) begin
    for (int v = 0; v < 4; v++) begin
      lx4[v] <= obvc_pkg::rshift14(50'(cb3) * 50'(dx3[v]) + 50'(sb3) * 50'(dy3[v]));
      ly4[v] <= obvc_pkg::rshift14(50'(cb3) * 50'(dy3[v]) - 50'(sb3) * 50'(dx3[v]));
    end
    cb4 <= cb3; sb4 <= sb3;
    hwa4 <= hwa3; hha4 <= hha3; hwb4 <= hwb3; hhb4 <= hhb3;
  end

  // stage 5: per corner shallowest edge
  logic               in5 [4];
  logic signed [36:0] dep5 [4];
  obvc_pkg::edge_t    edg5 [4];
  logic signed [35:0] lx5 [4];
  logic signed [35:0] ly5 [4];
  logic signed [15:0] cb5, sb5;
  logic signed [31:0] hwa5, hha5, hwb5, hhb5;
  always_ff @(posedge clk) begin
    for (int v = 0; v < 4; v++) begin
      logic signed [36:0] d;
      logic signed [36:0] t;
      obvc_pkg::edge_t e;
      d = 37'(ly4[v]) + 37'(hhb4);
      e = obvc_pkg::EDGE_BOTTOM;
      t = 37'(hwb4) - 37'(lx4[v]);
      if (d > t) begin d = t; e = obvc_pkg::EDGE_RIGHT; end
      t = 37'(hhb4) - 37'(ly4[v]);
      if (d > t) begin d = t; e = obvc_pkg::EDGE_TOP; end
      t = 37'(lx4[v]) + 37'(hwb4);
      if (d > t) begin d = t; e = obvc_pkg::EDGE_LEFT; end
      in5[v] <= (lx4[v] > -36'(hwb4)) && (lx4[v] < 36'(hwb4)) &&
                (ly4[v] > -36'(hhb4)) && (ly4[v] < 36'(hhb4));
      dep5[v] <= d;
      edg5[v] <= e;
      lx5[v] <= lx4[v];
      ly5[v] <= ly4[v];
    end
    cb5 <= cb4; sb5 <= sb4;
    hwa5 <= hwa4; hha5 <= hha4; hwb5 <= hwb4; hhb5 <= hhb4;
  end

  // stage 6: deepest corner
  obvc_pkg::contact_t res6;
  always_ff @(posedge clk) begin
    logic signed [36:0] best;
    obvc_pkg::contact_t r;
    best = '0;
    r = '0;
    for (int v = 0; v < 4; v++) begin
      if (in5[v] && dep5[v] > best) begin
        best = dep5[v];
        r.contact_found = 1'b1;
        r.corner_a_x = (v == 0 || v == 3) ? -hwa5 : hwa5;
        r.corner_a_y = (v < 2) ? -hha5 : hha5;
        unique case (edg5[v])
          obvc_pkg::EDGE_BOTTOM: begin
            r.normal_x = sb5; r.normal_y = -cb5;
            r.edge_point_b_x = lx5[v][31:0]; r.edge_point_b_y = -hhb5;
          end
          obvc_pkg::EDGE_RIGHT: begin
            r.normal_x = cb5; r.normal_y = sb5;
            r.edge_point_b_x = hwb5; r.edge_point_b_y = ly5[v][31:0];
          end
          obvc_pkg::EDGE_TOP: begin
            r.normal_x = -sb5; r.normal_y = cb5;
            r.edge_point_b_x = lx5[v][31:0]; r.edge_point_b_y = hhb5;
          end
          default: begin
            r.normal_x = -cb5; r.normal_y = -sb5;
            r.edge_point_b_x = -hwb5; r.edge_point_b_y = ly5[v][31:0];
          end
        endcase
      end
    end
    r.penetration = best[30:0];
    res6 <= r;
  end

  // output queue
  obvc_pkg::contact_t     mem [obvc_pkg::FifoDepth];
  logic [PtrW-1:0]        wptr, rptr;
  logic                   pop;
  assign pop = out.valid && out.ready;
  assign out.valid = (count != '0);
  assign out.data = mem[rptr];

  always_ff @(posedge clk) begin
    if (vld[Stages-1]) mem[wptr] <= res6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (vld[Stages-1]) wptr <= wptr + PtrW'(1);
      if (pop) rptr <= rptr + PtrW'(1);
      count <= count + (PtrW+1)'(vld[Stages-1]) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW+1)'(obvc_pkg::FifoDepth)) else $error("queue overflow");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(Stages+1) (count != '0)) else $error("result missing");
  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !out.valid) else $error("valid with empty queue");

endmodule

@@ verif/tb_oriented_box_vertex_contact.sv @@
// testbench: streams box pairs through the vertex contact block and checks each result
`timescale 1ns / 1ps
module tb_oriented_box_vertex_contact;

  localparam int unsigned CycleLimit = 400000;
  localparam longint One = 65536;

  logic clk;
  logic rst;

  obvc_stream_if #(.payload_t(obvc_pkg::box_pair_t)) in_if (clk);
  obvc_stream_if #(.payload_t(obvc_pkg::contact_t))  out_if (clk);

  oriented_box_vertex_contact dut (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if)
  );

  obvc_pkg::contact_t pending_contacts[$];
  longint      sine_tab[0:64];
  int unsigned errors;
  int unsigned cycles;
  int unsigned pairs_sent;
  int unsigned contacts_seen;
  int unsigned results_seen;
  int unsigned stall_pct;
  int unsigned burst_left;
  bit          hold_req;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // q1.14 sine table from a q30 chebyshev recurrence, capped at one
  function automatic longint q30_to_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    return (r > 16384) ? 16384 : r;
  endfunction

  function automatic void fill_sine_tab();
    longint prv;
    longint cur;
    longint nxt;
    prv = 0;
    cur = 26350943;
    sine_tab[0] = 0;
    sine_tab[1] = q30_to_q14(cur);
    for (int k = 1; k < 64; k++) begin
      nxt = ((64'sd2146836866 * cur + (64'sd1 <<< 29)) >>> 30) - prv;
      if (nxt < 0) nxt = 0;
      prv = cur;
      cur = nxt;
      sine_tab[k + 1] = q30_to_q14(cur);
    end
  endfunction

  function automatic longint table_sine(input logic [15:0] ang);
    logic [1:0]  quad;
    int unsigned p;
    int unsigned idx;
    longint      v;
    quad = ang[15:14];
    p = ang[13:0];
    if (quad[0]) p = 16384 - p;
    idx = p >> 8;
    if (idx >= 64) v = sine_tab[64];
    else v = sine_tab[idx] + (((sine_tab[idx + 1] - sine_tab[idx]) * (p & 255) + 128) >>> 8);
    return quad[1] ? -v : v;
  endfunction

  function automatic longint round_q14(input longint x);
    return (x + 8192) >>> 14;
  endfunction

  function automatic obvc_pkg::contact_t predict_contact(input obvc_pkg::box_pair_t p);
    longint   ax, ay, bx, by, ca, sa, cb, sb, hwa, hha, hwb, hhb;
    longint   cx, cy, wx, wy, dx, dy, lx, ly, depth, d, best;
    obvc_pkg::edge_t    side;
    obvc_pkg::contact_t r;
    ax = p.a_pos_x;
    ay = p.a_pos_y;
    bx = p.b_pos_x;
    by = p.b_pos_y;
    ca = table_sine(p.a_angle + 16'd16384);
    sa = table_sine(p.a_angle);
    cb = table_sine(p.b_angle + 16'd16384);
    sb = table_sine(p.b_angle);
    hwa = longint'(p.a_width) >> 1;
    hha = longint'(p.a_height) >> 1;
    hwb = longint'(p.b_width) >> 1;
    hhb = longint'(p.b_height) >> 1;
    best = 0;
    r = '0;
    for (int v = 0; v < 4; v++) begin
      cx = (v == 0 || v == 3) ? -hwa : hwa;
      cy = (v < 2) ? -hha : hha;
      wx = ax + round_q14(ca * cx - sa * cy);
      wy = ay + round_q14(sa * cx + ca * cy);
      dx = wx - bx;
      dy = wy - by;
      lx = round_q14(cb * dx + sb * dy);
      ly = round_q14(cb * dy - sb * dx);
      if (!(lx > -hwb && lx < hwb && ly > -hhb && ly < hhb)) continue;
      side = obvc_pkg::EDGE_BOTTOM;
      depth = ly + hhb;
      d = hwb - lx;
      if (depth > d) begin side = obvc_pkg::EDGE_RIGHT; depth = d; end
      d = hhb - ly;
      if (depth > d) begin side = obvc_pkg::EDGE_TOP; depth = d; end
      d = lx + hwb;
      if (depth > d) begin side = obvc_pkg::EDGE_LEFT; depth = d; end
      if (depth > best) begin
        best = depth;
        r.contact_found = 1'b1;
        r.penetration = depth[30:0];
        r.corner_a_x = cx[31:0];
        r.corner_a_y = cy[31:0];
        case (side)
          obvc_pkg::EDGE_BOTTOM: begin
            r.normal_x = sb[15:0]; r.normal_y = 16'(-cb);
            r.edge_point_b_x = lx[31:0]; r.edge_point_b_y = 32'(-hhb);
          end
          obvc_pkg::EDGE_RIGHT: begin
            r.normal_x = cb[15:0]; r.normal_y = sb[15:0];
            r.edge_point_b_x = hwb[31:0]; r.edge_point_b_y = ly[31:0];
          end
          obvc_pkg::EDGE_TOP: begin
            r.normal_x = 16'(-sb); r.normal_y = cb[15:0];
            r.edge_point_b_x = lx[31:0]; r.edge_point_b_y = hhb[31:0];
          end
          default: begin
            r.normal_x = 16'(-cb); r.normal_y = 16'(-sb);
            r.edge_point_b_x = 32'(-hwb); r.edge_point_b_y = ly[31:0];
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic obvc_pkg::box_pair_t make_pair(input longint ax, ay,
                                          input int unsigned aang,
                                          input longint aw, ah, bx, by,
                                          input int unsigned bang, input longint bw, bh);
    obvc_pkg::box_pair_t p;
    p.a_pos_x = ax[31:0];  p.a_pos_y = ay[31:0];  p.a_angle = aang[15:0];
    p.a_width = aw[30:0];  p.a_height = ah[30:0];
    p.b_pos_x = bx[31:0];  p.b_pos_y = by[31:0];  p.b_angle = bang[15:0];
    p.b_width = bw[30:0];  p.b_height = bh[30:0];
    return p;
  endfunction

  // one beat on the input channel; gaps come after some of the random-length bursts
  task automatic send_pair(input obvc_pkg::box_pair_t p);
    in_if.valid <= 1'b1;
    in_if.data  <= p;
    do @(posedge clk); while (!in_if.ready);
    pending_contacts = {pending_contacts, predict_contact(p)};
    pairs_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_done = 1'b0;
    wait (hold_req);
    repeat (300) @(posedge clk);
    hold_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      obvc_pkg::contact_t e;
      obvc_pkg::contact_t a;
      a = out_if.data;
      results_seen++;
      if (a.contact_found) contacts_seen++;
      if (pending_contacts.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        e = pending_contacts.pop_front();
        if (a.contact_found !== e.contact_found) begin
          $error("contact_found exp %0d got %0d", e.contact_found, a.contact_found); errors++;
        end
        if (a.penetration !== e.penetration) begin
          $error("penetration exp %0d got %0d", e.penetration, a.penetration); errors++;
        end
        if (a.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, a.normal_x); errors++;
        end
        if (a.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, a.normal_y); errors++;
        end
        if (a.corner_a_x !== e.corner_a_x) begin
          $error("corner_a_x exp %0d got %0d", e.corner_a_x, a.corner_a_x); errors++;
        end
        if (a.corner_a_y !== e.corner_a_y) begin
          $error("corner_a_y exp %0d got %0d", e.corner_a_y, a.corner_a_y); errors++;
        end
        if (a.edge_point_b_x !== e.edge_point_b_x) begin
          $error("edge_point_b_x exp %0d got %0d", e.edge_point_b_x, a.edge_point_b_x);
          errors++;
        end
        if (a.edge_point_b_y !== e.edge_point_b_y) begin
          $error("edge_point_b_y exp %0d got %0d", e.edge_point_b_y, a.edge_point_b_y);
          errors++;
        end
      end
    end
  end

  function automatic obvc_pkg::box_pair_t overlapping_pair();
    longint bx, by, bw, bh, aw, ah;
    bx = $signed($urandom) >>> $urandom_range(1, 12);
    by = $signed($urandom) >>> $urandom_range(1, 12);
    bw = $urandom_range(1, 200) * One / 4 + $urandom_range(0, 65535);
    bh = $urandom_range(1, 200) * One / 4 + $urandom_range(0, 65535);
    aw = $urandom_range(1, 200) * One / 4 + $urandom_range(0, 65535);
    ah = $urandom_range(1, 200) * One / 4 + $urandom_range(0, 65535);
    return make_pair(bx + longint'($urandom_range(0, 2 * bw)) - bw,
                     by + longint'($urandom_range(0, 2 * bh)) - bh,
                     $urandom_range(0, 65535), aw, ah, bx, by,
                     $urandom_range(0, 65535), bw, bh);
  endfunction

  function automatic obvc_pkg::box_pair_t noise_pair();
    obvc_pkg::box_pair_t p;
    p.a_pos_x = $urandom;  p.a_pos_y = $urandom;  p.a_angle = 16'($urandom);
    p.a_width = 31'($urandom);  p.a_height = 31'($urandom);
    p.b_pos_x = $urandom;  p.b_pos_y = $urandom;  p.b_angle = 16'($urandom);
    p.b_width = 31'($urandom);  p.b_height = 31'($urandom);
    return p;
  endfunction

  task automatic test_directed();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, One, One, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 2 * One, 2 * One, 0, 0, 0, 2 * One, 2 * One));
    send_pair(make_pair(0, 0, 0, One, One, 0, 0, 0, 4 * One, 4 * One));
    send_pair(make_pair(0, 0, 0, One, 2 * One, 0, 0, 0, 4 * One, 4 * One));
    for (int q = 0; q < 4; q++) begin
      send_pair(make_pair(0, 0, q * 16384, One, One, 0, 0, q * 16384, 4 * One, 4 * One));
    end
    send_pair(make_pair(0, -3 * One / 2, 0, One, One, 0, 0, 0, 4 * One, 4 * One));
    send_pair(make_pair(3 * One / 2, 0, 0, One, One, 0, 0, 0, 4 * One, 4 * One));
    send_pair(make_pair(0, 3 * One / 2, 0, One, One, 0, 0, 0, 4 * One, 4 * One));
    send_pair(make_pair(-3 * One / 2, 0, 0, One, One, 0, 0, 0, 4 * One, 4 * One));
    send_pair(make_pair(One, One, 8192, 2 * One, One, 0, 0, 24576, 6 * One, 3 * One));
    send_pair(make_pair(0, 0, 65535, One, One, 0, 0, 65535, 3 * One, 3 * One));
    send_pair(make_pair(0, 0, 0, 64'h7FFFFFFF, 64'h7FFFFFFF, 0, 0, 0,
                        64'h7FFFFFFF, 64'h7FFFFFFF));
    send_pair(make_pair(64'h7FFFFFFF, 64'h7FFFFFFF, 65535, 64'h7FFFFFFF, 64'h7FFFFFFF,
                        -64'sh80000000, -64'sh80000000, 65535, 64'h7FFFFFFF, 64'h7FFFFFFF));
    send_pair(make_pair(-64'sh80000000, -64'sh80000000, 12345, 64'h7FFFFFFF, 3,
                        -64'sh80000000, -64'sh80000000, 54321, 3, 64'h7FFFFFFF));
    send_pair(make_pair(0, 0, 0, One, One, 0, 0, 0, 4 * One, 1));
    send_pair(make_pair(5, 5, 100, 3, 3, 0, 0, 200, 40, 40));
    drain();
  endtask

  task automatic test_random_contacts(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      stall_pct = (i % 400 < 100) ? 0 : (i % 400 < 250) ? 30 : 70;
      send_pair(($urandom_range(0, 9) < 8) ? overlapping_pair() : noise_pair());
    end
    drain();
  endtask

  task automatic test_backpressure();
    stall_pct = 10;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_pair(overlapping_pair());
    drain();
    hold_req = 1'b0;
  endtask

  initial begin
    errors = 0;
    pairs_sent = 0;
    contacts_seen = 0;
    results_seen = 0;
    burst_left = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    fill_sine_tab();
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_contacts(1300);
    test_backpressure();
    $display("%0d box pairs sent, %0d results checked, %0d with a contact",
             pairs_sent, results_seen, contacts_seen);
    $display("covered directed edges and extremes, random overlaps and noise, long output stall");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/obvc_pkg.sv
hdl/obvc_stream_if.sv
hdl/oriented_box_vertex_contact.sv
verif/tb_oriented_box_vertex_contact.sv
